/* src/fds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_pkg: shared types for the forth data stack
// Operation codes, status codes, the stack word type and the execute result.
// ----------------------------------------------------------------------------
package fds_pkg;

  // width of one stack word
  localparam int WordW = 16;
  // width of the reported depth
  localparam int DepthW = 5;

  typedef logic signed [WordW-1:0] word_t;

  // operation codes as carried by the kind field
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DUP   = 3'd2,
    OP_SWAP  = 3'd3,
    OP_DROP  = 3'd4,
    OP_OVER  = 3'd5,
    OP_ROT   = 3'd6,
    OP_CLEAR = 3'd7
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // outcome of one operation, from the execute logic to the state registers
  typedef struct packed {
    status_e status;
    word_t   popped;
    logic    grow;    // one entry added, old third word spills to memory
    logic    shrink;  // one entry removed, third word refills from memory
    logic    empty;   // stack cleared
    word_t   top0;    // new top of stack
    word_t   top1;    // new second entry
    word_t   top2;    // new third entry
  } exec_t;

endpackage

/* src/fds_stack_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_stack_ram: storage for the entries below the top three
// One write port and one registered read port; a read of the address written
// in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module fds_stack_ram #(
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  fds_pkg::word_t        wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output fds_pkg::word_t        rd_data_o
);

  fds_pkg::word_t mem_q [DEPTH];
  fds_pkg::word_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, write data forwarded on an address match
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/fds_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_exec: operation decode and bounds check
// Works out status, popped word and the new top three entries for one word.
// ----------------------------------------------------------------------------
module fds_exec #(
  parameter int  STACK_DEPTH = 16,
  localparam int CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic [2:0]      kind_i,
  input  fds_pkg::word_t  push_value_i,
  input  logic [CW-1:0]   count_i,
  input  fds_pkg::word_t  top0_i,
  input  fds_pkg::word_t  top1_i,
  input  fds_pkg::word_t  top2_i,
  input  fds_pkg::word_t  spill_i,
  output fds_pkg::exec_t  exec_o
);

  logic has1;
  logic has2;
  logic has3;
  logic full;

  // bounds on the current depth
  assign has1 = (count_i >= CW'(1));
  assign has2 = (count_i >= CW'(2));
  assign has3 = (count_i >= CW'(3));
  assign full = (count_i >= CW'(STACK_DEPTH));

  // per operation outcome
  always_comb begin
    exec_o        = '0;
    exec_o.status = fds_pkg::ST_OK;
    exec_o.top0   = top0_i;
    exec_o.top1   = top1_i;
    exec_o.top2   = top2_i;
    case (fds_pkg::op_e'(kind_i))
      fds_pkg::OP_PUSH: begin
        if (full) begin
          exec_o.status = fds_pkg::ST_OVERFLOW;
        end else begin
          exec_o.grow = 1'b1;
          exec_o.top0 = push_value_i;
          exec_o.top1 = top0_i;
          exec_o.top2 = top1_i;
        end
      end
      fds_pkg::OP_POP, fds_pkg::OP_DROP: begin
        if (!has1) begin
          exec_o.status = fds_pkg::ST_UNDERFLOW;
        end else begin
          exec_o.shrink = 1'b1;
          if (fds_pkg::op_e'(kind_i) == fds_pkg::OP_POP) begin
            exec_o.popped = top0_i;
          end
          exec_o.top0 = top1_i;
          exec_o.top1 = top2_i;
          exec_o.top2 = spill_i;
        end
      end
      fds_pkg::OP_DUP: begin
        if (!has1) begin
          exec_o.status = fds_pkg::ST_UNDERFLOW;
        end else if (full) begin
          exec_o.status = fds_pkg::ST_OVERFLOW;
        end else begin
          exec_o.grow = 1'b1;
          exec_o.top0 = top0_i;
          exec_o.top1 = top0_i;
          exec_o.top2 = top1_i;
        end
      end
      fds_pkg::OP_SWAP: begin
        if (!has2) begin
          exec_o.status = fds_pkg::ST_UNDERFLOW;
        end else begin
          exec_o.top0 = top1_i;
          exec_o.top1 = top0_i;
        end
      end
      fds_pkg::OP_OVER: begin
        if (!has2) begin
          exec_o.status = fds_pkg::ST_UNDERFLOW;
        end else if (full) begin
          exec_o.status = fds_pkg::ST_OVERFLOW;
        end else begin
          exec_o.grow = 1'b1;
          exec_o.top0 = top1_i;
          exec_o.top1 = top0_i;
          exec_o.top2 = top1_i;
        end
      end
      fds_pkg::OP_ROT: begin
        if (!has3) begin
          exec_o.status = fds_pkg::ST_UNDERFLOW;
        end else begin
          exec_o.top0 = top2_i;
          exec_o.top1 = top0_i;
          exec_o.top2 = top1_i;
        end
      end
      fds_pkg::OP_CLEAR: begin
        exec_o.empty = 1'b1;
      end
      default: begin
        exec_o.empty = 1'b1;
      end
    endcase
  end

endmodule

/* src/forth_data_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack: data stack of signed 16-bit words
// Push, pop, dup, swap, drop, over, rot and clear with bounds checking.
// ----------------------------------------------------------------------------
// The stack takes one operation word per clock while the result register is
// not stalled and returns one registered result word per operation, in the
// cycle after the word is taken; back-to-back words run at a rate of one per
// cycle unless the output stalls. The top three entries live in registers,
// the rest in a single-port-write memory whose next word to refill is
// prefetched by its registered read port. A failed operation reports overflow
// or underflow and leaves the stack as it was. Memory contents are undefined
// after reset and need no clearing pass; the block is ready from the first
// cycle after reset. depth_now carries the entry count in five bits.
module forth_data_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                kind_i,
  input  logic signed [15:0]        push_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic signed [15:0]        popped_value_o,
  output logic [4:0]                depth_now_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic                  accept;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         count_d;
  fds_pkg::word_t        top0_q;
  fds_pkg::word_t        top1_q;
  fds_pkg::word_t        top2_q;
  fds_pkg::word_t        spill;
  fds_pkg::exec_t        exec;
  logic                  wr_en;
  logic [CW-1:0]         wr_index;
  logic [CW-1:0]         rd_index;
  logic                  out_valid_q;
  fds_pkg::status_e      status_q;
  fds_pkg::word_t        popped_q;
  logic [CW-1:0]         depth_q;

  // handshake: take a word unless the result register is stuck
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // operation decode
  fds_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .kind_i       (kind_i),
    .push_value_i (push_value_i),
    .count_i      (count_q),
    .top0_i       (top0_q),
    .top1_i       (top1_q),
    .top2_i       (top2_q),
    .spill_i      (spill),
    .exec_o       (exec)
  );

  // next entry count
  always_comb begin
    count_d = count_q;
    if (exec.empty) begin
      count_d = '0;
    end else if (exec.grow) begin
      count_d = count_q + CW'(1);
    end else if (exec.shrink) begin
      count_d = count_q - CW'(1);
    end
  end

  // spill of the old third entry, prefetch of the new one below the top three
  assign wr_en    = accept && exec.grow && (count_q >= CW'(3));
  assign wr_index = count_q - CW'(3);
  assign rd_index = count_d - CW'(4);

  fds_stack_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_index[AW-1:0]),
    .wr_data_i (top2_q),
    .rd_en_i   (accept),
    .rd_addr_i (rd_index[AW-1:0]),
    .rd_data_o (spill)
  );

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // top of stack registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top0_q <= exec.top0;
      top1_q <= exec.top1;
      top2_q <= exec.top2;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= exec.status;
      popped_q <= exec.popped;
      depth_q  <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign depth_now_o    = 5'(depth_q);

  // entry count never passes the stack size
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count above stack depth");

  // a failed operation leaves the entry count alone
  a_error_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (exec.status != fds_pkg::ST_OK) |=> count_q == $past(count_q))
    else $error("entry count changed on error");

  // overflow only on a full stack
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (exec.status == fds_pkg::ST_OVERFLOW) |-> count_q == CW'(STACK_DEPTH))
    else $error("overflow on a stack that is not full");

  // a spill only happens when three entries already sit in registers
  a_spill_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (count_q >= CW'(3)) && (count_q < CW'(STACK_DEPTH)))
    else $error("spill write out of range");

endmodule

/* tb/forth_data_stack_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_tb: self-checking bench for the forth data stack
// Feeds push, pop, dup, swap, drop, over, rot and clear words through the
// valid/stall input channel. Each accepted word goes through a stack model
// kept in the bench, and each result word is checked field by field against
// the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module forth_data_stack_tb;

  localparam int Depth      = 16;
  localparam int IdleLimit  = 5000;
  localparam int TargetCmds = 1450;

  typedef struct {
    fds_pkg::op_e   kind;
    fds_pkg::word_t value;
  } stack_cmd_t;

  typedef struct {
    fds_pkg::status_e           status;
    fds_pkg::word_t             popped;
    logic [fds_pkg::DepthW-1:0] depth;
  } stack_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        kind_i;
  logic signed [15:0] push_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic signed [15:0] popped_value_o;
  logic [4:0]        depth_now_o;

  forth_data_stack #(
    .STACK_DEPTH(Depth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .depth_now_o   (depth_now_o)
  );

  // stimulus and expectation stores
  stack_cmd_t    pending_cmds[$];
  stack_result_t expected_results[$];

  // stack model state
  fds_pkg::word_t model_words[Depth];
  int             model_count;

  int  cmds_total;
  int  cmds_accepted;
  int  error_count;
  int  idle_cycles;
  bit  run_started;
  bit  cmd_taken;

  // clock, 8 ns period
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // idling percentages per phase of the run
  function automatic int sender_idle_pct();
    if (cmds_accepted < cmds_total / 3) return 24;
    if (cmds_accepted < (2 * cmds_total) / 3) return 87;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (cmds_accepted < cmds_total / 3) return 87;
    if (cmds_accepted < (2 * cmds_total) / 3) return 24;
    return 0;
  endfunction

  // apply one operation to the model stack and return its result word
  function automatic stack_result_t run_stack_op(fds_pkg::op_e op, fds_pkg::word_t value);
    stack_result_t  r;
    fds_pkg::word_t t;
    int             n;
    n        = model_count;
    r.status = fds_pkg::ST_OK;
    r.popped = '0;
    case (op)
      fds_pkg::OP_PUSH: begin
        if (n >= Depth) r.status = fds_pkg::ST_OVERFLOW;
        else begin
          model_words[n] = value;
          model_count = n + 1;
        end
      end
      fds_pkg::OP_POP: begin
        if (n < 1) r.status = fds_pkg::ST_UNDERFLOW;
        else begin
          r.popped = model_words[n-1];
          model_count = n - 1;
        end
      end
      fds_pkg::OP_DUP: begin
        if (n < 1) r.status = fds_pkg::ST_UNDERFLOW;
        else if (n >= Depth) r.status = fds_pkg::ST_OVERFLOW;
        else begin
          model_words[n] = model_words[n-1];
          model_count = n + 1;
        end
      end
      fds_pkg::OP_SWAP: begin
        if (n < 2) r.status = fds_pkg::ST_UNDERFLOW;
        else begin
          t = model_words[n-1];
          model_words[n-1] = model_words[n-2];
          model_words[n-2] = t;
        end
      end
      fds_pkg::OP_DROP: begin
        if (n < 1) r.status = fds_pkg::ST_UNDERFLOW;
        else model_count = n - 1;
      end
      fds_pkg::OP_OVER: begin
        if (n < 2) r.status = fds_pkg::ST_UNDERFLOW;
        else if (n >= Depth) r.status = fds_pkg::ST_OVERFLOW;
        else begin
          model_words[n] = model_words[n-2];
          model_count = n + 1;
        end
      end
      fds_pkg::OP_ROT: begin
        if (n < 3) r.status = fds_pkg::ST_UNDERFLOW;
        else begin
          t = model_words[n-3];
          model_words[n-3] = model_words[n-2];
          model_words[n-2] = model_words[n-1];
          model_words[n-1] = t;
        end
      end
      default: model_count = 0;
    endcase
    r.depth = model_count[fds_pkg::DepthW-1:0];
    return r;
  endfunction

  // push values lean toward the extremes now and then
  function automatic fds_pkg::word_t pick_word();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return fds_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic add_cmd(fds_pkg::op_e kind, fds_pkg::word_t value);
    stack_cmd_t c;
    c.kind  = kind;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  // operation mix for ordinary stack work
  function automatic fds_pkg::op_e pick_work_op();
    case ($urandom_range(9))
      0, 1: return fds_pkg::OP_SWAP;
      2, 3: return fds_pkg::OP_ROT;
      4: return fds_pkg::OP_OVER;
      5: return fds_pkg::OP_DUP;
      6: return fds_pkg::OP_POP;
      7: return fds_pkg::OP_DROP;
      default: return fds_pkg::OP_PUSH;
    endcase
  endfunction

  task automatic build_stimulus();
    int seq_len;
    // directed: underflow on an empty stack for every operation that reads
    add_cmd(fds_pkg::OP_CLEAR, pick_word());
    add_cmd(fds_pkg::OP_POP, 16'sh1234);
    add_cmd(fds_pkg::OP_DROP, 16'sh0000);
    add_cmd(fds_pkg::OP_DUP, 16'shffff);
    add_cmd(fds_pkg::OP_SWAP, 16'sh7fff);
    add_cmd(fds_pkg::OP_OVER, 16'sh8000);
    add_cmd(fds_pkg::OP_ROT, 16'sh5555);
    // one entry: swap, over and rot still too shallow
    add_cmd(fds_pkg::OP_PUSH, 16'sh7fff);
    add_cmd(fds_pkg::OP_SWAP, 16'sh0000);
    add_cmd(fds_pkg::OP_OVER, 16'sh0000);
    add_cmd(fds_pkg::OP_ROT, 16'sh0000);
    add_cmd(fds_pkg::OP_DUP, 16'shaaaa);
    // two entries: rot still too shallow
    add_cmd(fds_pkg::OP_ROT, 16'sh0000);
    add_cmd(fds_pkg::OP_PUSH, 16'sh8000);
    add_cmd(fds_pkg::OP_SWAP, 16'sh0000);
    add_cmd(fds_pkg::OP_OVER, 16'sh0000);
    add_cmd(fds_pkg::OP_ROT, 16'sh0000);
    add_cmd(fds_pkg::OP_PUSH, 16'shffff);
    add_cmd(fds_pkg::OP_PUSH, 16'sh0000);
    add_cmd(fds_pkg::OP_POP, 16'sh0000);
    add_cmd(fds_pkg::OP_POP, 16'sh0000);
    add_cmd(fds_pkg::OP_DROP, 16'sh0000);
    add_cmd(fds_pkg::OP_CLEAR, 16'sh0000);
    add_cmd(fds_pkg::OP_POP, 16'sh0000);

    // random sequences until the item budget is used up
    while (pending_cmds.size() < TargetCmds) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          // fill to full or beyond, then drain, at times past empty
          if ($urandom_range(3) != 0) add_cmd(fds_pkg::OP_CLEAR, pick_word());
          add_cmd(fds_pkg::OP_PUSH, pick_word());
          add_cmd(fds_pkg::OP_PUSH, pick_word());
          seq_len = $urandom_range(17, 14);
          repeat (seq_len) begin
            case ($urandom_range(3))
              0: add_cmd(fds_pkg::OP_DUP, pick_word());
              1: add_cmd(fds_pkg::OP_OVER, pick_word());
              default: add_cmd(fds_pkg::OP_PUSH, pick_word());
            endcase
          end
          seq_len = $urandom_range(19, 10);
          repeat (seq_len)
            add_cmd($urandom_range(1) ? fds_pkg::OP_POP : fds_pkg::OP_DROP, pick_word());
        end
        3, 4, 5, 6, 7: begin
          // a few pushes followed by stack shuffling
          if ($urandom_range(1)) add_cmd(fds_pkg::OP_CLEAR, pick_word());
          seq_len = $urandom_range(10, 3);
          repeat (seq_len) add_cmd(fds_pkg::OP_PUSH, pick_word());
          seq_len = $urandom_range(24, 8);
          repeat (seq_len) add_cmd(pick_work_op(), pick_word());
        end
        default: begin
          // noise: any operation, any value
          seq_len = $urandom_range(16, 4);
          repeat (seq_len)
            add_cmd(fds_pkg::op_e'($urandom_range(7)), fds_pkg::word_t'($urandom));
        end
      endcase
    end
    cmds_total = pending_cmds.size();
  endtask

  // driver: present words from the queue, hold them while stalled
  always @(negedge clk_i) begin : drive
    stack_cmd_t nxt;
    if (in_valid_i && !cmd_taken) begin
      // stalled word stays on the bus
    end else if (run_started && pending_cmds.size() > 0 &&
                 $urandom_range(99) >= sender_idle_pct()) begin
      nxt = pending_cmds.pop_front();
      in_valid_i   <= 1'b1;
      kind_i       <= nxt.kind;
      push_value_i <= nxt.value;
    end else begin
      in_valid_i <= 1'b0;
    end
    if (run_started) out_stall_i <= ($urandom_range(99) < receiver_idle_pct());
  end

  // monitor: check result words, predict on accepted input words
  always @(posedge clk_i) begin : watch
    stack_result_t exp_r;
    bit            any_taken;
    any_taken = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      any_taken = 1'b1;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d popped %0d depth %0d",
                 $time, status_o, popped_value_o, depth_now_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          error_count++;
        end
        if (popped_value_o !== exp_r.popped) begin
          $display("%0t: popped_value expected %0d actual %0d",
                   $time, exp_r.popped, popped_value_o);
          error_count++;
        end
        if (depth_now_o !== exp_r.depth) begin
          $display("%0t: depth_now expected %0d actual %0d",
                   $time, exp_r.depth, depth_now_o);
          error_count++;
        end
      end
    end
    cmd_taken = rst_ni && in_valid_i && !in_stall_o;
    if (cmd_taken) begin
      any_taken = 1'b1;
      expected_results.push_back(run_stack_op(fds_pkg::op_e'(kind_i), push_value_i));
      cmds_accepted++;
    end
    // watchdog on a stuck handshake
    if (any_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = fds_pkg::OP_CLEAR;
    push_value_i  = '0;
    out_stall_i   = 1'b0;
    run_started   = 1'b0;
    cmd_taken     = 1'b0;
    cmds_accepted = 0;
    cmds_total    = 1;
    error_count   = 0;
    idle_cycles   = 0;
    model_count   = 0;
    foreach (model_words[i]) model_words[i] = '0;
    build_stimulus();

    // reset held, then released on a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_started = 1'b1;

    // wait for every word to go in and every result to come back
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
